### rtl/core/vcmc_pkg.sv
// ----------------------------------------------------------------------------
// vcmc_pkg
// Shared types and constants for the FIFO vertex cache miss counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcmc_pkg;

  localparam int unsigned CacheEntries = 32;
  localparam int unsigned PtrW         = $clog2(CacheEntries);
  localparam int unsigned TagW         = 32;
  localparam int unsigned CntW         = 32;
  localparam int unsigned Vc3W         = CntW + 2;
  localparam int unsigned Vc105W       = CntW + 7;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [TagW-1:0] vertex_index;
    logic            last_index;
  } vcmc_req_t;

  typedef struct packed {
    logic            was_hit;
    logic [CntW-1:0] miss_count;
    logic [CntW-1:0] index_count;
    logic            needs_reorder;
    logic            is_last;
  } vcmc_rsp_t;

  typedef struct packed {
    logic was_hit;
    logic is_last;
  } vcmc_cls_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + CntW'(1);
  endfunction

endpackage

### rtl/core/vcmc_front.sv
// ----------------------------------------------------------------------------
// vcmc_front
// Accepts indices, looks them up in the FIFO cache and classifies hit or miss.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcmc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vcmc_pkg::vcmc_req_t in_req_i,
  output logic                cls_valid_o,
  input  logic                cls_ready_i,
  output vcmc_pkg::vcmc_cls_t cls_o
);

  logic [vcmc_pkg::TagW-1:0]         tag_q [vcmc_pkg::CacheEntries];
  logic [vcmc_pkg::CacheEntries-1:0] valid_q, valid_d;
  logic [vcmc_pkg::PtrW-1:0]         ptr_q, ptr_d;
  logic [vcmc_pkg::CacheEntries-1:0] match;
  logic                              hit;
  logic                              accept;

  assign in_ready_o  = cls_ready_i;
  assign cls_valid_o = in_valid_i;
  assign accept      = in_valid_i && cls_ready_i;

  always_comb begin
    for (int n = 0; n < vcmc_pkg::CacheEntries; n++) begin
      match[n] = valid_q[n] && (tag_q[n] == in_req_i.vertex_index);
    end
  end

  assign hit = |match;
  assign cls_o.was_hit = hit;
  assign cls_o.is_last = in_req_i.last_index;

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (accept) begin
      if (!hit) begin
        valid_d[ptr_q] = 1'b1;
        ptr_d = (ptr_q == vcmc_pkg::PtrW'(vcmc_pkg::CacheEntries - 1)) ?
                '0 : ptr_q + vcmc_pkg::PtrW'(1);
      end
      if (in_req_i.last_index) begin
        valid_d = '0;
        ptr_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !hit) begin
      tag_q[ptr_q] <= in_req_i.vertex_index;
    end
  end

endmodule

### rtl/core/vcmc_queue.sv
// ----------------------------------------------------------------------------
// vcmc_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcmc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  vcmc_pkg::vcmc_cls_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output vcmc_pkg::vcmc_cls_t rd_data_o
);

  vcmc_pkg::vcmc_cls_t        mem_q [vcmc_pkg::QueueDepth];
  logic [vcmc_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [vcmc_pkg::QCntW-1:0] cnt_q;
  logic                       push, pop;

  assign wr_ready_o = (cnt_q != vcmc_pkg::QCntW'(vcmc_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == vcmc_pkg::QPtrW'(vcmc_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + vcmc_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == vcmc_pkg::QPtrW'(vcmc_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + vcmc_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + vcmc_pkg::QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - vcmc_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/core/vcmc_back.sv
// ----------------------------------------------------------------------------
// vcmc_back
// Saturating miss and index counters, end-of-mesh reorder test, s1 and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcmc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [vcmc_pkg::CntW-1:0] cfg_data_i,
  input  logic                      cls_valid_i,
  output logic                      cls_ready_o,
  input  vcmc_pkg::vcmc_cls_t       cls_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output vcmc_pkg::vcmc_rsp_t       out_rsp_o
);

  logic [vcmc_pkg::Vc3W-1:0]   vc3_q;
  logic [vcmc_pkg::Vc105W-1:0] vc105_q;
  logic                        vc_big_q;

  logic [vcmc_pkg::CntW-1:0]   miss_q, idx_q, miss_n, idx_n;

  logic                        s1_valid_q;
  logic                        s1_hit_q, s1_last_q;
  logic [vcmc_pkg::CntW-1:0]   s1_miss_q, s1_idx_q;

  logic                        out_valid_q;
  vcmc_pkg::vcmc_rsp_t         out_q;

  logic                        out_adv, s1_adv, take;
  logic [vcmc_pkg::Vc105W-1:0] miss100;
  logic                        reorder;

  assign out_adv     = !out_valid_q || out_ready_i;
  assign s1_adv      = !s1_valid_q || out_adv;
  assign cls_ready_o = s1_adv;
  assign take        = s1_adv && cls_valid_i;

  assign miss_n = cls_i.was_hit ? miss_q : vcmc_pkg::sat_inc(miss_q);
  assign idx_n  = vcmc_pkg::sat_inc(idx_q);

  assign miss100 = vcmc_pkg::Vc105W'(s1_miss_q) * vcmc_pkg::Vc105W'(100);
  assign reorder = s1_last_q && vc_big_q &&
                   ({1'b0, s1_idx_q, 1'b0} >= vc3_q) &&
                   (miss100 >= vc105_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc3_q    <= '0;
      vc105_q  <= '0;
      vc_big_q <= 1'b0;
    end else if (cfg_valid_i) begin
      vc3_q    <= vcmc_pkg::Vc3W'(cfg_data_i) * vcmc_pkg::Vc3W'(3);
      vc105_q  <= vcmc_pkg::Vc105W'(cfg_data_i) * vcmc_pkg::Vc105W'(105);
      vc_big_q <= (cfg_data_i >= vcmc_pkg::CntW'(2 * vcmc_pkg::CacheEntries));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q      <= '0;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        miss_q <= cls_i.is_last ? '0 : miss_n;
        idx_q  <= cls_i.is_last ? '0 : idx_n;
      end
      if (s1_adv) begin
        s1_valid_q <= cls_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_hit_q  <= cls_i.was_hit;
      s1_last_q <= cls_i.is_last;
      s1_miss_q <= miss_n;
      s1_idx_q  <= idx_n;
    end
    if (out_adv && s1_valid_q) begin
      out_q.was_hit       <= s1_hit_q;
      out_q.miss_count    <= s1_miss_q;
      out_q.index_count   <= s1_idx_q;
      out_q.needs_reorder <= reorder;
      out_q.is_last       <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### rtl/core/vertex_cache_miss_counter.sv
// ----------------------------------------------------------------------------
// vertex_cache_miss_counter
// FIFO vertex cache simulation with miss counting and an end-of-mesh test.
// Throughput: one request per cycle (32 parallel tag compares in the front) while
// the queue has room; responses pass the queue, s1 and output registers.
// Reset: cache empty, counters and vertex count zero; ready from the first cycle.
// After a request marked last, cache and counters clear for the next mesh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_cache_miss_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [vcmc_pkg::CntW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  vcmc_pkg::vcmc_req_t       in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output vcmc_pkg::vcmc_rsp_t       out_rsp_o
);

  logic                cls_valid, cls_ready;
  vcmc_pkg::vcmc_cls_t cls;
  logic                q_valid, q_ready;
  vcmc_pkg::vcmc_cls_t q_data;

  assign cfg_ready_o = 1'b1;

  vcmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_o       (cls)
  );

  vcmc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cls_valid),
    .wr_ready_o (cls_ready),
    .wr_data_i  (cls),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  vcmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cls_valid_i (q_valid),
    .cls_ready_o (q_ready),
    .cls_i       (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

### test/vcmc_miss_checker.sv
// ----------------------------------------------------------------------------
// vcmc_miss_checker
// Watches the config, request and response channels of the vertex cache miss
// counter. It keeps its own FIFO cache, counters and vertex count, predicts
// one response per accepted request and compares each accepted response with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcmc_miss_checker
  import vcmc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  vcmc_req_t       in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  vcmc_rsp_t       out_rsp_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  localparam int unsigned ReportLimit = 10;

  logic [TagW-1:0] line_tag   [CacheEntries];
  logic            line_valid [CacheEntries];
  logic [PtrW-1:0] fill_ptr;
  logic [CntW-1:0] miss_total;
  logic [CntW-1:0] index_total;
  logic [CntW-1:0] vertex_count;
  vcmc_rsp_t       expected_rsp [$];
  int unsigned     reports;

  task automatic clear_mesh();
    for (int n = 0; n < CacheEntries; n++) begin
      line_valid[n] = 1'b0;
      line_tag[n]   = '0;
    end
    fill_ptr    = '0;
    miss_total  = '0;
    index_total = '0;
  endtask

  task automatic predict_lookup(input vcmc_req_t req);
    vcmc_rsp_t   rsp;
    logic        hit;
    logic [63:0] verts;
    logic [63:0] seen;
    logic [63:0] missed;
    hit = 1'b0;
    for (int n = 0; n < CacheEntries; n++) begin
      if (line_valid[n] && line_tag[n] == req.vertex_index) begin
        hit = 1'b1;
      end
    end
    if (!hit) begin
      line_tag[fill_ptr]   = req.vertex_index;
      line_valid[fill_ptr] = 1'b1;
      fill_ptr   = (fill_ptr == PtrW'(CacheEntries - 1)) ? '0 : fill_ptr + PtrW'(1);
      miss_total = (miss_total == '1) ? miss_total : miss_total + CntW'(1);
    end
    index_total = (index_total == '1) ? index_total : index_total + CntW'(1);
    verts  = 64'(vertex_count);
    seen   = 64'(index_total);
    missed = 64'(miss_total);
    rsp.was_hit       = hit;
    rsp.miss_count    = miss_total;
    rsp.index_count   = index_total;
    rsp.needs_reorder = req.last_index
                        && (seen * 64'd2 >= verts * 64'd3)
                        && (verts >= 64'(2 * CacheEntries))
                        && (missed * 64'd100 >= verts * 64'd105);
    rsp.is_last       = req.last_index;
    expected_rsp.push_back(rsp);
    if (req.last_index) begin
      clear_mesh();
    end
  endtask

  task automatic check_response(input vcmc_rsp_t got);
    vcmc_rsp_t exp;
    if (expected_rsp.size() == 0) begin
      fail_count_o++;
      if (reports < ReportLimit) begin
        reports++;
        $display("vcmc: unexpected response hit=%0b miss=%0d idx=%0d reorder=%0b last=%0b",
                 got.was_hit, got.miss_count, got.index_count, got.needs_reorder,
                 got.is_last);
      end
    end else begin
      exp = expected_rsp.pop_front();
      if (got.was_hit !== exp.was_hit || got.miss_count !== exp.miss_count
          || got.index_count !== exp.index_count
          || got.needs_reorder !== exp.needs_reorder || got.is_last !== exp.is_last) begin
        fail_count_o++;
        if (reports < ReportLimit) begin
          reports++;
          $display("vcmc: mismatch exp hit=%0b miss=%0d idx=%0d reorder=%0b last=%0b",
                   exp.was_hit, exp.miss_count, exp.index_count, exp.needs_reorder,
                   exp.is_last);
          $display("vcmc:          got hit=%0b miss=%0d idx=%0d reorder=%0b last=%0b",
                   got.was_hit, got.miss_count, got.index_count, got.needs_reorder,
                   got.is_last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_mesh();
      vertex_count = '0;
      expected_rsp.delete();
      fail_count_o = 0;
      pending_o    = 0;
      reports      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        vertex_count = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_lookup(in_req_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_response(out_rsp_i);
      end
      pending_o = expected_rsp.size();
    end
  end

endmodule

### test/vertex_cache_miss_counter_tb.sv
// ----------------------------------------------------------------------------
// vertex_cache_miss_counter_tb
// Drives index streams through the vertex cache miss counter: a short directed
// set, then random meshes of varied length and index locality under several
// vertex counts, with random idling, a long output stall and a steady stretch.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_cache_miss_counter_tb;
  import vcmc_pkg::*;

  localparam int unsigned RandomItems = 1200;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned Latency     = 3;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 6;

  typedef enum int unsigned {
    MeshWide,
    MeshHot,
    MeshSpill,
    MeshRing,
    MeshStrip
  } mesh_style_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CntW-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  vcmc_req_t       in_req;
  logic            out_valid;
  logic            out_ready;
  vcmc_rsp_t       out_rsp;
  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     cycles;
  logic            steady;
  logic            hold_req;
  logic            hold_done;

  vertex_cache_miss_counter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  vcmc_miss_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // response side: random backpressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic push_index(input logic [TagW-1:0] idx, input logic last);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{vertex_index: idx, last_index: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [CntW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CntW-1:0] pick_vertex_count(input int unsigned phase);
    case (phase)
      0:       return '0;
      1:       return CntW'(64);
      2:       return CntW'(63);
      3:       return CntW'(100);
      4:       return '1;
      5:       return CntW'(96);
      6:       return CntW'(66);
      default: begin
        case ($urandom_range(3))
          0:       return CntW'($urandom_range(150));
          1:       return $urandom;
          2:       return CntW'(64);
          default: return CntW'($urandom_range(80, 40));
        endcase
      end
    endcase
  endfunction

  task automatic run_mesh(input int unsigned len, input mesh_style_e style,
                          inout int unsigned sent);
    logic [TagW-1:0] base;
    logic [TagW-1:0] idx;
    int unsigned     period;
    base   = $urandom;
    period = $urandom_range(34, 30);
    for (int unsigned k = 0; k < len; k++) begin
      case (style)
        MeshWide:  idx = $urandom;
        MeshHot:   idx = base + $urandom_range(7);
        MeshSpill: idx = base + $urandom_range(39);
        MeshRing:  idx = base + (k % period);
        default:   idx = base + k / 2 + $urandom_range(5);
      endcase
      push_index(idx, k == len - 1);
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned meshes;
    int unsigned len;
    mesh_style_e style;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    sent      = 0;
    phase     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_vertex_count('0);
    push_index('0, 1'b0);
    push_index('1, 1'b0);
    push_index('0, 1'b0);
    push_index('1, 1'b1);
    push_index(TagW'(5), 1'b1);
    push_index(32'hAAAA_AAAA, 1'b0);
    push_index(32'h5555_5555, 1'b0);
    push_index(32'hAAAA_AAAA, 1'b1);
    // cache cleared by the previous last request: must miss again
    push_index(32'hAAAA_AAAA, 1'b1);
    settle();

    while (sent < RandomItems) begin
      write_vertex_count(pick_vertex_count(phase));
      steady = (phase == 5 || phase == 6);
      meshes = $urandom_range(4, 2);
      for (int unsigned m = 0; m < meshes; m++) begin
        if ($urandom_range(5) == 0) begin
          len = $urandom_range(200, 90);
        end else begin
          len = $urandom_range(60, 1);
        end
        style = mesh_style_e'($urandom_range(4));
        if (phase == 3 && m == 0) begin
          hold_req = 1'b1;
          len      = 200;
          style    = MeshWide;
        end
        run_mesh(len, style, sent);
      end
      settle();
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
